/* rtl/lftq_pkg.sv */
// ----------------------------------------------------------------------------
// lftq_pkg: log frame transmit queue shared types and constants
// Payload structs, command and status codes, register indexes and the
// control/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lftq_pkg;

  // Field widths fixed by the interface
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned STATUS_W = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTICE_LEN  = 1'd1;

  // Register reset values
  localparam logic [PERIOD_W-1:0] DROP_PERIOD_RST = 16'd200;
  localparam logic [LEN_W-1:0]    NOTICE_LEN_RST  = 8'd47;

  // Item commands
  localparam logic CMD_LOG     = 1'b0;
  localparam logic CMD_TX_DONE = 1'b1;

  // Request status codes
  localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_REQ = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [LEN_W-1:0]  frame_length;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] request_status;
    logic                start_send;
    logic                send_drop_notice;
    logic [SLOT_W-1:0]   send_slot;
    logic [LEN_W-1:0]    send_length;
    logic                transmitter_busy;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;   // capture the accepted item
    logic eval;    // decide and update queue state
    logic fetch;   // read the started slot
    logic load;    // load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_fetch;
    logic tx_busy;
    logic q_empty;
  } dp_stat_t;

endpackage

/* rtl/lftq_ctrl.sv */
// ----------------------------------------------------------------------------
// lftq_ctrl: sequencing controller
// Walks one item through evaluate, optional slot fetch and result load,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module lftq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  lftq_pkg::dp_stat_t stat_i,
  output lftq_pkg::ctrl_cmd_t cmd_o
);
  import lftq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = stat_i.need_fetch ? S_FETCH : S_RESP;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Set valid on load, drop it once the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/lftq_dp.sv */
// ----------------------------------------------------------------------------
// lftq_dp: queue datapath
// Holds the slot ring, pointers, transmitter and drop-notice state, the
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module lftq_dp #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lftq_pkg::in_t                       in_data_i,
  input  logic                                cfg_we_i,
  input  logic [lftq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lftq_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  lftq_pkg::ctrl_cmd_t                 cmd_i,
  output lftq_pkg::dp_stat_t                  stat_o,
  output lftq_pkg::out_t                      out_data_o
);
  import lftq_pkg::*;

  localparam int unsigned PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [PW-1:0] LAST_SLOT = PW'(SLOTS - 1);

  // Configuration
  logic [PERIOD_W-1:0] period_q;
  logic [LEN_W-1:0]    notice_len_q;

  // Captured item
  logic              cmd_q;
  logic [LEN_W-1:0]  len_q;
  logic [TIME_W-1:0] now_q;

  // Queue and transmitter state
  logic [PW-1:0]     head_q, head_d, tail_q, tail_d;
  logic              busy_q, busy_d;
  logic              pend_q, pend_d;
  logic [TIME_W-1:0] last_q, last_d;

  // Decision of the evaluate step
  logic [STATUS_W-1:0] status_q, status_d;
  logic                start_q, start_d;
  logic                notice_q, notice_d;
  logic [PW-1:0]       slot_q;
  logic                wr_en;

  logic [LEN_W-1:0] slot_mem [SLOTS];
  logic [LEN_W-1:0] rd_q;

  logic [PW-1:0]     head_inc, tail_inc;
  logic [TIME_W-1:0] gap;
  logic [PW+SLOT_W-1:0] slot_ext;
  out_t              out_q, out_d;

  assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
  assign gap      = now_q - last_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= DROP_PERIOD_RST;
      notice_len_q <= NOTICE_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DROP_PERIOD: period_q     <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_NOTICE_LEN:  notice_len_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= in_data_i.cmd;
      len_q <= in_data_i.frame_length;
      now_q <= in_data_i.now_ms;
    end
  end

  // Decide store, drop, notice or start
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    busy_d   = busy_q;
    pend_d   = pend_q;
    last_d   = last_q;
    status_d = ST_NOT_REQ;
    start_d  = 1'b0;
    notice_d = 1'b0;
    wr_en    = 1'b0;
    if (cmd_q == CMD_LOG) begin
      if (head_inc == tail_q) begin
        pend_d   = 1'b1;
        status_d = ST_DROPPED;
      end else begin
        wr_en    = 1'b1;
        head_d   = head_inc;
        status_d = ST_STORED;
      end
      if (!busy_q && (head_d != tail_q)) begin
        start_d = 1'b1;
        tail_d  = tail_inc;
        busy_d  = 1'b1;
      end
    end else begin
      if (pend_q && (gap > {{(TIME_W-PERIOD_W){1'b0}}, period_q})) begin
        notice_d = 1'b1;
        last_d   = now_q;
        pend_d   = 1'b0;
        busy_d   = 1'b1;
      end else if (head_q != tail_q) begin
        start_d = 1'b1;
        tail_d  = tail_inc;
        busy_d  = 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  // Advance control state on evaluate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      last_q <= '0;
    end else if (cmd_i.eval) begin
      head_q <= head_d;
      tail_q <= tail_d;
      busy_q <= busy_d;
      pend_q <= pend_d;
      last_q <= last_d;
    end
  end

  // Hold the decision for the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      status_q <= status_d;
      start_q  <= start_d;
      notice_q <= notice_d;
      slot_q   <= tail_q;
    end
  end

  // Slot ring: write on evaluate, registered read on fetch
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && wr_en) begin
      slot_mem[head_q] <= len_q;
    end
    if (cmd_i.fetch) begin
      rd_q <= slot_mem[slot_q];
    end
  end

  // Form the result
  assign slot_ext = {{SLOT_W{1'b0}}, slot_q};

  always_comb begin
    out_d                  = '0;
    out_d.request_status   = status_q;
    out_d.start_send       = start_q;
    out_d.send_drop_notice = notice_q;
    out_d.transmitter_busy = busy_q;
    if (start_q) begin
      out_d.send_slot   = slot_ext[SLOT_W-1:0];
      out_d.send_length = rd_q;
    end else if (notice_q) begin
      out_d.send_length = notice_len_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o        = out_q;
  assign stat_o.need_fetch = start_d;
  assign stat_o.tx_busy    = busy_q;
  assign stat_o.q_empty    = (head_q == tail_q);

endmodule

/* rtl/log_frame_transmit_queue_top.sv */
// ----------------------------------------------------------------------------
// log_frame_transmit_queue_top: transmit scheduler for log frames
// Queues frame lengths in a slot ring, starts the oldest on transmit done or
// on a request while idle; sends a rate-limited notice after dropped requests.
// ----------------------------------------------------------------------------
// Steps: latch, evaluate, fetch from the slot ring when a slot is started,
// and load once the result port is free; the fetch step is for the registered
// read port of the ring. A new item is taken once the last result is loaded.
// Reset: pointers, flags and notice time clear and configuration registers load
// their reset values at once; the slot ring is not cleared and needs no clearing pass.
module log_frame_transmit_queue_top #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lftq_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lftq_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [lftq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lftq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lftq_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  lftq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  lftq_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // An idle transmitter never leaves frames waiting
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !dp_stat.tx_busy |-> dp_stat.q_empty)
    else $error("transmitter idle with frames queued");

  // A result never appears the cycle after a transfer in
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !ctrl_cmd.load)
    else $error("result loaded too early");

  // Frame start and drop notice are exclusive
  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.start_send && out_data_o.send_drop_notice))
    else $error("frame and notice started together");

  // Anything started leaves the transmitter busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.start_send || out_data_o.send_drop_notice)
    |-> out_data_o.transmitter_busy)
    else $error("start reported with idle transmitter");
`endif

endmodule

/* sim/log_frame_transmit_queue_top_test.sv */
// ----------------------------------------------------------------------------
// log_frame_transmit_queue_top_test: self-checking bench for the log frame
// transmit queue
// Drives log requests and transmit-done events through the valid/stall input
// port. Each transfer in is run through a cycle-free model of the slot ring,
// the transmitter flag and the rate-limited drop notice, and every result
// transfer is checked field by field against the oldest predicted dispatch.
// Directed items fill the ring, overflow it, probe the notice period
// boundary and wrap the time. Random request and done bursts then run under
// several register settings, with random gaps on both ports but in one phase.
// ----------------------------------------------------------------------------
module log_frame_transmit_queue_top_test;
  import lftq_pkg::*;

  localparam int unsigned RING_SLOTS  = 1 << SLOT_W;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 205;

  // Model of the queue: predicts one dispatch record per accepted transfer
  class dispatch_checker;
    logic [PERIOD_W-1:0] drop_period;
    logic [LEN_W-1:0]    notice_len;
    logic [SLOT_W-1:0]   head;
    logic [SLOT_W-1:0]   tail;
    logic [LEN_W-1:0]    slot_len [RING_SLOTS];
    bit                  tx_busy;
    bit                  notice_owed;
    logic [TIME_W-1:0]   last_notice;
    out_t                expected_dispatches [$];
    int unsigned         errors;
    int unsigned         transfers;
    int unsigned         checked;
    int unsigned         drops;
    int unsigned         notices;
    int unsigned         frame_starts;

    function new();
      drop_period = DROP_PERIOD_RST;
      notice_len  = NOTICE_LEN_RST;
      head        = '0;
      tail        = '0;
      tx_busy     = 1'b0;
      notice_owed = 1'b0;
      last_notice = '0;
      foreach (slot_len[i]) slot_len[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DROP_PERIOD: drop_period = val[PERIOD_W-1:0];
        CFG_NOTICE_LEN:  notice_len  = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Start the oldest waiting frame, if any
    function bit start_oldest(inout out_t r);
      if (head == tail) return 1'b0;
      r.start_send  = 1'b1;
      r.send_slot   = tail;
      r.send_length = slot_len[tail];
      tail          = tail + 1'b1;
      tx_busy       = 1'b1;
      frame_starts++;
      return 1'b1;
    endfunction

    function void note_transfer(in_t item);
      out_t              r;
      logic [SLOT_W-1:0] nxt;
      logic [TIME_W-1:0] elapsed;
      r = '0;
      transfers++;
      if (item.cmd == CMD_LOG) begin
        nxt = head + 1'b1;
        if (nxt == tail) begin
          notice_owed      = 1'b1;
          r.request_status = ST_DROPPED;
          drops++;
        end else begin
          slot_len[head]   = item.frame_length;
          head             = nxt;
          r.request_status = ST_STORED;
        end
        if (!tx_busy) void'(start_oldest(r));
      end else begin
        r.request_status = ST_NOT_REQ;
        elapsed = item.now_ms - last_notice;
        if (notice_owed && elapsed > TIME_W'(drop_period)) begin
          last_notice        = item.now_ms;
          notice_owed        = 1'b0;
          tx_busy            = 1'b1;
          r.send_drop_notice = 1'b1;
          r.send_length      = notice_len;
          notices++;
        end else if (!start_oldest(r)) begin
          tx_busy = 1'b0;
        end
      end
      r.transmitter_busy = tx_busy;
      expected_dispatches.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (expected_dispatches.size() == 0) begin
        $error("result transfer with no dispatch pending");
        errors++;
        return;
      end
      exp_r = expected_dispatches.pop_front();
      checked++;
      compare_field("request_status", exp_r.request_status, got.request_status);
      compare_field("start_send", exp_r.start_send, got.start_send);
      compare_field("send_drop_notice", exp_r.send_drop_notice, got.send_drop_notice);
      compare_field("send_slot", exp_r.send_slot, got.send_slot);
      compare_field("send_length", exp_r.send_length, got.send_length);
      compare_field("transmitter_busy", exp_r.transmitter_busy, got.transmitter_busy);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  dispatch_checker   chk = new();
  bit                steady;
  logic [TIME_W-1:0] clock_ms;
  int unsigned       cycle_count;

  log_frame_transmit_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Stall the result port at random, except during a steady stretch
  initial out_stall_i = 1'b0;
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 13);
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) chk.check_result(out_data_o);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL log_frame_transmit_queue_top");
      $finish;
    end
  end

  function automatic in_t pack_item(logic cmd, logic [LEN_W-1:0] len, logic [TIME_W-1:0] now);
    in_t item;
    item.cmd          = cmd;
    item.frame_length = len;
    item.now_ms       = now;
    return item;
  endfunction

  // Offer one item, with random idle cycles ahead of it; starts and ends at a
  // falling edge
  task automatic push_item(input in_t item);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = item;
    do @(posedge clk_i); while (in_stall_o);
    chk.note_transfer(item);
    @(negedge clk_i);
  endtask

  // Hold off input until every dispatch has come back, then let the block settle
  task automatic drain_queue();
    in_valid_i = 1'b0;
    while (chk.expected_dispatches.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    chk.write_reg(idx, val);
  endtask

  // Ring fill, overflow, notice period boundary and time wrap
  task automatic run_directed();
    logic [LEN_W-1:0] len;
    push_item(pack_item(CMD_TX_DONE, 8'hFF, 32'd0));
    push_item(pack_item(CMD_LOG, 8'd0, 32'd0));
    for (int i = 0; i < RING_SLOTS - 1; i++) begin
      len = (i == 0) ? 8'hFF : ((8'd1 << (i % 8)) ^ ((i >= 8) ? 8'hFF : 8'h00));
      push_item(pack_item(CMD_LOG, len, 32'd0));
    end
    push_item(pack_item(CMD_LOG, 8'hFF, 32'd0));
    push_item(pack_item(CMD_TX_DONE, 8'h00, 32'd200));
    push_item(pack_item(CMD_TX_DONE, 8'h00, 32'd201));
    push_item(pack_item(CMD_LOG, 8'h5A, 32'd201));
    push_item(pack_item(CMD_LOG, 8'hA5, 32'd201));
    push_item(pack_item(CMD_TX_DONE, 8'h00, 32'd401));
    push_item(pack_item(CMD_LOG, 8'h3C, 32'd401));
    push_item(pack_item(CMD_LOG, 8'hC3, 32'd401));
    push_item(pack_item(CMD_TX_DONE, 8'h00, 32'hFFFF_FFFF));
  endtask

  // Move the time forward: same ms, small steps, the notice period boundary,
  // or a jump anywhere
  task automatic advance_clock();
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4, 5: clock_ms = clock_ms + $urandom_range(0, 300);
      6, 7: clock_ms = chk.last_notice + chk.drop_period + $urandom_range(0, 2) - 1;
      default: clock_ms = $urandom();
    endcase
  endtask

  // Alternate bursts of requests and done events, with some fully random items
  task automatic run_random(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    bit          log_burst;
    left      = count;
    log_burst = 1'b1;
    while (left > 0) begin
      burst = $urandom_range(1, 18);
      if (burst > left) burst = left;
      repeat (burst) begin
        if ($urandom_range(0, 99) < 10) begin
          push_item(pack_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom()));
        end else begin
          advance_clock();
          push_item(pack_item(log_burst ? CMD_LOG : CMD_TX_DONE, 8'($urandom_range(0, 255)),
                              clock_ms));
        end
      end
      left      = left - burst;
      log_burst = !log_burst;
    end
  endtask

  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_DROP_PERIOD;
    cfg_wdata_i = '0;
    steady      = 1'b0;
    clock_ms    = '0;
    rst_ni      = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset register values
    run_directed();
    run_random(PHASE_ITEMS);
    drain_queue();

    // Low extremes
    write_cfg(CFG_DROP_PERIOD, 16'd0);
    write_cfg(CFG_NOTICE_LEN, 16'd0);
    run_random(PHASE_ITEMS);
    drain_queue();

    // High extremes, with no gaps on either port
    write_cfg(CFG_DROP_PERIOD, 16'hFFFF);
    write_cfg(CFG_NOTICE_LEN, 16'h00FF);
    steady = 1'b1;
    run_random(PHASE_ITEMS);
    drain_queue();
    steady = 1'b0;

    // Random settings
    write_cfg(CFG_DROP_PERIOD, 16'($urandom_range(0, 65535)));
    write_cfg(CFG_NOTICE_LEN, 16'($urandom_range(0, 255)));
    run_random(PHASE_ITEMS);
    drain_queue();

    write_cfg(CFG_DROP_PERIOD, 16'd1);
    write_cfg(CFG_NOTICE_LEN, 16'($urandom_range(0, 255)));
    run_random(PHASE_ITEMS);
    drain_queue();

    $display("Ran %0d transfers, checked %0d results under five register settings",
             chk.transfers, chk.checked);
    $display("Saw %0d dropped requests, %0d drop notices and %0d frame starts",
             chk.drops, chk.notices, chk.frame_starts);
    if (chk.errors == 0) begin
      $display("PASS log_frame_transmit_queue_top");
    end else begin
      $display("FAIL log_frame_transmit_queue_top");
    end
    $finish;
  end

endmodule
